[sv/mse_pkg.sv]
`default_nettype none

package mse_pkg;

  // entries of the command queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // classification attached to every accepted item
  typedef struct packed {
    logic keep;   // value is stored
    logic last;   // closes the set
    logic ovf;    // set has dropped a value up to and including this item
  } mse_flags_t;

endpackage

`default_nettype wire

[sv/mse_ram.sv]
`default_nettype none

module mse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

[sv/mse_queue.sv]
`default_nettype none

module mse_queue
  import mse_pkg::*;
#(
  parameter int W = 40
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push_valid,
  output logic              push_ready,
  input  wire logic [W-1:0] push_data,
  output logic              pop_valid,
  input  wire logic         pop_ready,
  output logic      [W-1:0] pop_data
);

  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]   entries [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] fill;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (fill != QCW'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[sv/mse_front.sv]
`default_nettype none

module mse_front
  import mse_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic signed [31:0]               element,
  input  wire logic                             last_element,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  output logic                                  push_valid,
  input  wire logic                             push_ready,
  output logic        [DATA_WIDTH-1:0]          push_value,
  output logic        [$clog2(DEPTH+1)-1:0]     push_total,
  output mse_flags_t                            push_flags
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]            count;
  logic                     ovf;
  logic                     keep;
  logic [CW-1:0]            total_next;
  logic                     ovf_next;
  logic [DATA_WIDTH+31:0]   ext;
  logic                     take;

  // bits above the value width are dropped, narrower values are zero-extended
  assign ext        = {{DATA_WIDTH{1'b0}}, $unsigned(element)};
  assign keep       = (count < CW'(DEPTH));
  assign total_next = count + CW'(keep);
  assign ovf_next   = ovf || !keep;
  assign take       = in_valid && push_ready;

  assign in_ready        = push_ready;
  assign push_valid      = in_valid;
  assign push_value      = ext[DATA_WIDTH-1:0];
  assign push_total      = total_next;
  assign push_flags.keep = keep;
  assign push_flags.last = last_element;
  assign push_flags.ovf  = ovf_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (take) begin
      if (last_element) begin
        count <= '0;
        ovf   <= 1'b0;
      end else begin
        count <= total_next;
        ovf   <= ovf_next;
      end
    end
  end

endmodule

`default_nettype wire

[sv/mse_back.sv]
`default_nettype none

module mse_back
  import mse_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         descending,
  input  wire logic                         cmd_valid,
  output logic                              cmd_ready,
  input  wire logic [DATA_WIDTH-1:0]        cmd_value,
  input  wire logic [$clog2(DEPTH+1)-1:0]   cmd_total,
  input  mse_flags_t                        cmd_flags,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [DATA_WIDTH-1:0]        out_data,
  output logic                              out_last,
  output logic                              out_ovf
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = CW + 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MREAD,
    ST_MWRITE,
    ST_EREAD,
    ST_EOUT
  } state_t;

  state_t state;

  logic [PW-1:0] n;
  logic [PW-1:0] w;
  logic [PW-1:0] k;
  logic [PW-1:0] i;
  logic [PW-1:0] mid;
  logic [PW-1:0] j;
  logic [PW-1:0] hi;
  logic          buf_sel;
  logic          ovf_r;

  logic [PW-1:0] total_w;
  logic [PW-1:0] w2;
  logic [PW-1:0] nr_mid_raw;
  logic [PW-1:0] nr_hi_raw;
  logic [PW-1:0] nr_mid;
  logic [PW-1:0] nr_hi;
  logic [PW-1:0] np_mid;
  logic [PW-1:0] np_hi;

  logic [AW-1:0]         raddr_a;
  logic [AW-1:0]         raddr_b;
  logic [DATA_WIDTH-1:0] rd0_a, rd0_b, rd1_a, rd1_b;
  logic [DATA_WIDTH-1:0] src_a, src_b;
  logic                  b_first;
  logic                  take_i;
  logic [DATA_WIDTH-1:0] merge_data;
  logic                  pop;
  logic                  load;
  logic                  we0, we1;
  logic [AW-1:0]         waddr0;
  logic [DATA_WIDTH-1:0] wdata0;
  logic                  slot_free;
  logic                  run_end;
  logic                  at_last;

  assign cmd_ready = (state == ST_IDLE);
  assign pop       = cmd_valid && cmd_ready;
  assign load      = pop && cmd_flags.keep;
  assign total_w   = PW'(cmd_total);

  assign src_a   = buf_sel ? rd1_a : rd0_a;
  assign src_b   = buf_sel ? rd1_b : rd0_b;
  assign b_first = descending ? ($signed(src_b) > $signed(src_a))
                              : ($signed(src_b) < $signed(src_a));
  // equal keys leave the left run first, which keeps the sort stable
  assign take_i     = (i < mid) && ((j >= hi) || !b_first);
  assign merge_data = take_i ? src_a : src_b;

  assign w2         = w << 1;
  assign nr_mid_raw = hi + w;
  assign nr_hi_raw  = hi + w2;
  assign nr_mid     = (nr_mid_raw < n) ? nr_mid_raw : n;
  assign nr_hi      = (nr_hi_raw < n) ? nr_hi_raw : n;
  assign np_mid     = (w2 < n) ? w2 : n;
  assign np_hi      = ((w2 << 1) < n) ? (w2 << 1) : n;
  assign run_end    = (k + 1'b1 == hi);
  assign at_last    = (k + 1'b1 == n);

  assign raddr_a = (state == ST_EREAD || state == ST_EOUT) ? k[AW-1:0] : i[AW-1:0];
  assign raddr_b = j[AW-1:0];

  assign we0    = load || (state == ST_MWRITE && buf_sel);
  assign we1    = (state == ST_MWRITE) && !buf_sel;
  assign waddr0 = load ? AW'(cmd_total - 1'b1) : k[AW-1:0];
  assign wdata0 = load ? cmd_value : merge_data;

  assign slot_free = !out_valid || out_ready;

  mse_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_store (
    .clk     (clk),
    .we      (we0),
    .waddr   (waddr0),
    .wdata   (wdata0),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd0_a),
    .rdata_b (rd0_b)
  );

  mse_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_scratch (
    .clk     (clk),
    .we      (we1),
    .waddr   (k[AW-1:0]),
    .wdata   (merge_data),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd1_a),
    .rdata_b (rd1_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      buf_sel   <= 1'b0;
    end else begin
      if (state == ST_EOUT && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop && cmd_flags.last) begin
            n       <= total_w;
            ovf_r   <= cmd_flags.ovf;
            buf_sel <= 1'b0;
            k       <= '0;
            w       <= PW'(1);
            i       <= '0;
            mid     <= PW'(1);
            j       <= PW'(1);
            hi      <= (total_w > PW'(1)) ? PW'(2) : total_w;
            state   <= (total_w > PW'(1)) ? ST_MREAD : ST_EREAD;
          end
        end
        ST_MREAD: begin
          state <= ST_MWRITE;
        end
        ST_MWRITE: begin
          if (run_end && hi == n) begin
            buf_sel <= !buf_sel;
            k       <= '0;
            if (w2 >= n) begin
              state <= ST_EREAD;
            end else begin
              w     <= w2;
              i     <= '0;
              mid   <= np_mid;
              j     <= np_mid;
              hi    <= np_hi;
              state <= ST_MREAD;
            end
          end else if (run_end) begin
            k     <= k + 1'b1;
            i     <= hi;
            mid   <= nr_mid;
            j     <= nr_mid;
            hi    <= nr_hi;
            state <= ST_MREAD;
          end else begin
            k <= k + 1'b1;
            if (take_i) begin
              i <= i + 1'b1;
            end else begin
              j <= j + 1'b1;
            end
            state <= ST_MREAD;
          end
        end
        ST_EREAD: begin
          state <= ST_EOUT;
        end
        ST_EOUT: begin
          if (slot_free) begin
            out_data  <= src_a;
            out_last  <= at_last;
            out_ovf   <= ovf_r;
            if (at_last) begin
              state <= ST_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= ST_EREAD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/merge_sort_engine.sv]
// values are loaded one per cycle while the sort side is idle; each merge pass reads and
// then writes every value, and each emitted value is read and then presented; the single
// sort datapath serves one set at a time
// reset (rst, synchronous, active high) clears the queue, set count, overflow flag,
// sort state, output valid and the order bit; the value memories are not cleared
`default_nettype none

module merge_sort_engine
  import mse_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration: order select
  input  wire logic               cfg_we,
  input  wire logic               cfg_wdata,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] element,
  input  wire logic               last_element,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      sorted_value,
  output logic                    last_out,
  output logic                    overflowed
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int FW = $bits(mse_flags_t);
  localparam int QW = DATA_WIDTH + CW + FW;

  // order bit; the user must write it only while the engine is idle, the block does not enforce this
  logic descending;

  always_ff @(posedge clk) begin
    if (rst) begin
      descending <= 1'b0;
    end else if (cfg_we) begin
      descending <= cfg_wdata;
    end
  end

  // front side: classify each transfer as kept or dropped and track the set size
  logic                  push_valid;
  logic                  push_ready;
  logic [DATA_WIDTH-1:0] push_value;
  logic [CW-1:0]         push_total;
  mse_flags_t            push_flags;

  mse_front #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .element      (element),
    .last_element (last_element),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_value   (push_value),
    .push_total   (push_total),
    .push_flags   (push_flags)
  );

  // short command queue so the front keeps taking transfers while the back stalls
  logic          cmd_valid;
  logic          cmd_ready;
  logic [QW-1:0] cmd_word;

  mse_queue #(.W(QW)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_value, push_total, push_flags}),
    .pop_valid  (cmd_valid),
    .pop_ready  (cmd_ready),
    .pop_data   (cmd_word)
  );

  // back side: store values, bottom-up merge between two memories, then emit
  logic [DATA_WIDTH-1:0]  res_data;
  logic [DATA_WIDTH+31:0] res_ext;

  mse_back #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .descending (descending),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd_value  (cmd_word[QW-1 -: DATA_WIDTH]),
    .cmd_total  (cmd_word[FW +: CW]),
    .cmd_flags  (mse_flags_t'(cmd_word[FW-1:0])),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (res_data),
    .out_last   (last_out),
    .out_ovf    (overflowed)
  );

  // result carries the low value bits, zero-extended when the value is narrower
  assign res_ext      = {32'b0, res_data};
  assign sorted_value = $signed(res_ext[31:0]);

endmodule

`default_nettype wire
